// ----- design/ptb_pkg.sv -----
// shared constants and types for the periodic timer bank
package ptb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CW   = $clog2(NUM_SLOTS + 1);

  localparam int OP_W      = 2;
  localparam int PERIOD_W  = 32;
  localparam int SLOT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int TICK_W    = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_OPEN   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/periodic_timer_bank.sv -----
// periodic timer bank: slot periods and elapsed counts in ram, walked on each tick
//
//  channel  | dir | tdata fields (lsb first)                                  | beat
//  s_axis   | in  | op[1:0] period[33:2] slot[36:34] zero pad to 40          | one operation
//  m_axis   | out | fired_mask[7:0] create_ok[8] created_slot[11:9]
//           |     | tick_count[43:12] zero pad to 48                          | one result
//
//  tick: accept, then a walk that reads each slot in turn through the one ram read port, then the result
//  create, open, close: accept, then the result, then ready for the next accept
//  one operation at a time; the result beat waits in the output register until taken
//  reset clears flags, counts and handshake state; the ram needs no clearing pass
//  a stalled result holds the block in its output state, input stays not ready
module periodic_timer_bank (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ptb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // op, period, slot
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fired_mask, create_ok, created_slot, tick_count
  output logic [ptb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } state_t;

  state_t                            state;
  ptb_pkg::op_t                      op_q;
  logic [ptb_pkg::PERIOD_W-1:0]      period_q;
  logic [ptb_pkg::SLOT_W-1:0]        slot_q;
  logic [ptb_pkg::NUM_SLOTS-1:0]     active;
  logic [ptb_pkg::NUM_SLOTS-1:0]     written;
  logic [ptb_pkg::TICK_W-1:0]        ticks;
  logic [ptb_pkg::TICK_W-1:0]        ticks_next;
  logic [ptb_pkg::MASK_W-1:0]        fired;
  logic [ptb_pkg::SLOT_CW-1:0]       rd_cnt;
  logic                              rd_pend;
  logic [ptb_pkg::SLOT_IW-1:0]       rd_idx;

  logic                              ram_we;
  logic [ptb_pkg::SLOT_IW-1:0]       ram_waddr;
  ptb_pkg::entry_t                   ram_wdata;
  logic                              ram_re;
  logic [ptb_pkg::SLOT_IW-1:0]       ram_raddr;
  logic [ptb_pkg::ENTRY_W-1:0]       ram_rdata;

  ptb_pkg::entry_t                   cur;
  logic [ptb_pkg::PERIOD_W-1:0]      elapsed_inc;
  logic                              hit;
  logic                              out_free;
  logic                              free_found;
  logic [ptb_pkg::SLOT_IW-1:0]       free_idx;
  logic                              slot_ok;
  logic [ptb_pkg::SLOT_IW-1:0]       slot_sel;
  logic [ptb_pkg::OUT_TDATA_W-1:0]   out_data;

  ptb_ram #(
    .WIDTH (ptb_pkg::ENTRY_W),
    .DEPTH (ptb_pkg::NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign ticks_next    = ticks + ptb_pkg::TICK_W'(1);
  assign slot_ok       = (32'(slot_q) < ptb_pkg::NUM_SLOTS);
  assign slot_sel      = ptb_pkg::SLOT_IW'(slot_q);

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = ptb_pkg::SLOT_IW'(i);
      end
    end
  end

  // entries never written read as zero
  always_comb begin
    cur         = written[rd_idx] ? ptb_pkg::entry_t'(ram_rdata) : '0;
    elapsed_inc = cur.elapsed + ptb_pkg::PERIOD_W'(1);
    hit         = (elapsed_inc >= cur.period);
  end

  always_comb begin
    ram_re    = (state == ST_WALK) && (32'(rd_cnt) < ptb_pkg::NUM_SLOTS);
    ram_raddr = rd_cnt[ptb_pkg::SLOT_IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = '0;
    if (rd_pend && active[rd_idx]) begin
      ram_we            = 1'b1;
      ram_wdata.period  = cur.period;
      ram_wdata.elapsed = hit ? '0 : elapsed_inc;
    end else if (state == ST_OUT && out_free && op_q == ptb_pkg::OP_CREATE &&
                 free_found) begin
      ram_we            = 1'b1;
      ram_waddr         = free_idx;
      ram_wdata.period  = period_q;
      ram_wdata.elapsed = '0;
    end
  end

  // result beat for the operation in hand
  always_comb begin
    out_data        = '0;
    out_data[43:12] = ticks;
    if (op_q == ptb_pkg::OP_TICK) begin
      out_data[7:0]   = fired;
      out_data[43:12] = ticks_next;
    end else if (op_q == ptb_pkg::OP_CREATE && free_found) begin
      out_data[8]    = 1'b1;
      out_data[11:9] = ptb_pkg::SLOT_W'(free_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= '0;
      written       <= '0;
      ticks         <= '0;
      rd_cnt        <= '0;
      rd_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      rd_idx  <= ram_raddr;
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= out_data;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= ptb_pkg::op_t'(s_axis_tdata[1:0]);
            period_q <= s_axis_tdata[33:2];
            slot_q   <= s_axis_tdata[36:34];
            fired    <= '0;
            rd_cnt   <= '0;
            state    <= (ptb_pkg::op_t'(s_axis_tdata[1:0]) == ptb_pkg::OP_TICK) ?
                        ST_WALK : ST_OUT;
          end
        end
        ST_WALK: begin
          if (ram_re) begin
            rd_cnt <= rd_cnt + ptb_pkg::SLOT_CW'(1);
          end
          if (rd_pend && active[rd_idx] && hit) begin
            fired <= fired | (ptb_pkg::MASK_W'(1) << rd_idx);
          end
          if (!ram_re && !rd_pend) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            unique case (op_q)
              ptb_pkg::OP_TICK: begin
                ticks <= ticks_next;
              end
              ptb_pkg::OP_CREATE: begin
                if (free_found) begin
                  active[free_idx] <= 1'b1;
                end
              end
              ptb_pkg::OP_OPEN: begin
                if (slot_ok) begin
                  active[slot_sel] <= 1'b1;
                end
              end
              ptb_pkg::OP_CLOSE: begin
                if (slot_ok) begin
                  active[slot_sel] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // write-back never lands on the entry being read
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram write and read hit the same slot");

  // only a tick reports expiries
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free && op_q != ptb_pkg::OP_TICK)
    |=> (m_axis_tdata[7:0] == '0))
    else $error("fired mask set on a non-tick result");

  // a successful create leaves its slot active
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free && op_q == ptb_pkg::OP_CREATE && free_found)
    |=> active[ptb_pkg::SLOT_IW'(m_axis_tdata[11:9])])
    else $error("created slot not active");

  // the walk keeps a slot read in flight until it ends
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && $past(state) == ST_WALK) |-> (rd_pend || ram_re || $past(rd_pend)))
    else $error("slot walk stalled");

endmodule

// ----- design/ptb_ram.sv -----
// generic single-write, single-read ram with registered read data
module ptb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
